@@ hdl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg - shared types and constants for pressure compensation
// Payload structs, calibration word layout, fault codes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  // fault codes
  typedef enum logic [1:0] {
    FAULT_OK      = 2'd0,
    FAULT_SKIPPED = 2'd1,
    FAULT_DIVISOR = 2'd2,
    FAULT_RANGE   = 2'd3
  } fault_t;

  // configuration register indexes
  localparam logic [1:0] CFG_CAL_TEMP   = 2'd0;
  localparam logic [1:0] CFG_CAL_PLOW   = 2'd1;
  localparam logic [1:0] CFG_CAL_PHIGH  = 2'd2;
  localparam logic [1:0] CFG_CAL_P9     = 2'd3;

  // fixed constants of the compensation formula
  localparam logic [19:0]        RAW_SKIPPED = 20'h80000;
  localparam logic signed [19:0] TEMP_MIN    = -20'sd5000;
  localparam logic signed [19:0] TEMP_MAX    = 20'sd10000;
  localparam logic [63:0]        PRESS_MAX   = 64'd30720000;
  localparam logic [25:0]        T_OFFSET    = 26'd128000;
  localparam logic [27:0]        T_ROUND     = 28'd128;
  localparam logic [20:0]        PRESS_FULL  = 21'h100000;
  localparam logic [63:0]        D_BIAS      = 64'h0000_8000_0000_0000;
  localparam logic [11:0]        P_SCALE     = 12'd3125;

  // divider geometry
  localparam int DIV_BITS     = 64;
  localparam int DEN_W        = 31;
  localparam int FRONT_STAGES = 10;
  localparam int BACK_STAGES  = 6;
  localparam int LATENCY      = FRONT_STAGES + DIV_BITS + BACK_STAGES;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } sample_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi_c;
    logic [24:0]        pressure_q24_8_pa;
    logic               result_valid;
    fault_t             fault_code;
  } result_t;

  // unpacked calibration coefficients
  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // per-item status carried alongside the datapath
  typedef struct packed {
    logic               skip;
    logic               div_zero;
    logic               temp_bad;
    logic               neg;
    logic signed [14:0] temp;
  } side_t;

endpackage

`default_nettype wire

@@ hdl/bpc_front.sv @@
// ----------------------------------------------------------------------------
// bpc_front - temperature and pressure pre-division pipeline
// Ten stages: temperature compensation, divisor and dividend, magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_front import bpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  sample_t            sample,
  input  cal_t               cal,
  output logic               out_valid,
  output logic [63:0]        num_mag,
  output logic [DEN_W-1:0]   den_mag,
  output side_t              side
);

  logic [FRONT_STAGES-1:0] vld;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_STAGES-2:0], in_valid};
    end
  end
  assign out_valid = vld[FRONT_STAGES-1];

  // stage 1: offsets against t1
  logic signed [17:0] a_now, s1_a;
  logic signed [16:0] b_now, s1_b;
  logic [19:0]        s1_rp;
  side_t              sd_now, sd1;

  assign a_now = $signed({1'b0, sample.raw_temp[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
  assign b_now = $signed({1'b0, sample.raw_temp[19:4]}) - $signed({1'b0, cal.t1});

  always_comb begin
    sd_now      = '0;
    sd_now.skip = (sample.raw_temp == RAW_SKIPPED) || (sample.raw_press == RAW_SKIPPED);
  end

  always_ff @(posedge clk) begin
    s1_a  <= a_now;
    s1_b  <= b_now;
    s1_rp <= sample.raw_press;
    sd1   <= sd_now;
  end

  // stage 2: first products
  logic signed [33:0] s2_m1, s2_bb;
  logic [19:0]        s2_rp;
  side_t              sd2;

  always_ff @(posedge clk) begin
    s2_m1 <= s1_a * cal.t2;
    s2_bb <= s1_b * s1_b;
    s2_rp <= s1_rp;
    sd2   <= sd1;
  end

  // stage 3: second-order temperature term
  logic signed [21:0] bbs;
  logic signed [22:0] s3_v1;
  logic signed [37:0] s3_m2;
  logic [19:0]        s3_rp;
  side_t              sd3;

  assign bbs = s2_bb[33:12];

  always_ff @(posedge clk) begin
    s3_v1 <= s2_m1[33:11];
    s3_m2 <= bbs * cal.t3;
    s3_rp <= s2_rp;
    sd3   <= sd2;
  end

  // stage 4: fine temperature, centi-degrees, pressure offset
  logic signed [23:0] v2;
  logic signed [24:0] tf;
  logic [27:0]        t5;
  logic [19:0]        s4_temp;
  logic signed [25:0] s4_q1;
  logic [19:0]        s4_rp;
  side_t              sd4;

  assign v2 = s3_m2[37:14];
  assign tf = {{2{s3_v1[22]}}, s3_v1} + {v2[23], v2};
  assign t5 = {tf[24], tf, 2'b00} + {{3{tf[24]}}, tf} + T_ROUND;

  always_ff @(posedge clk) begin
    s4_temp <= t5[27:8];
    s4_q1   <= $signed({tf[24], tf} - T_OFFSET);
    s4_rp   <= s3_rp;
    sd4     <= sd3;
  end

  // stage 5: square and linear pressure terms, temperature range
  logic signed [51:0] s5_qq;
  logic signed [41:0] s5_qp5, s5_qp2;
  logic [19:0]        s5_rp;
  side_t              sd5_now, sd5;

  always_comb begin
    sd5_now          = sd4;
    sd5_now.temp     = s4_temp[14:0];
    sd5_now.temp_bad = ($signed(s4_temp) < TEMP_MIN) || ($signed(s4_temp) > TEMP_MAX);
  end

  always_ff @(posedge clk) begin
    s5_qq  <= s4_q1 * s4_q1;
    s5_qp5 <= s4_q1 * cal.p5;
    s5_qp2 <= s4_q1 * cal.p2;
    s5_rp  <= s4_rp;
    sd5    <= sd5_now;
  end

  // stage 6: quadratic coefficients, wrapping to 64 bits
  logic signed [67:0] q2a_full, q1b_full;
  logic [63:0]        s6_q2a, s6_q1b;
  logic signed [41:0] s6_qp5, s6_qp2;
  logic [19:0]        s6_rp;
  side_t              sd6;

  assign q2a_full = s5_qq * cal.p6;
  assign q1b_full = s5_qq * cal.p3;

  always_ff @(posedge clk) begin
    s6_q2a <= q2a_full[63:0];
    s6_q1b <= q1b_full[63:0];
    s6_qp5 <= s5_qp5;
    s6_qp2 <= s5_qp2;
    s6_rp  <= s5_rp;
    sd6    <= sd5;
  end

  // stage 7: sums for dividend offset and divisor
  logic [63:0] qp5x, qp2x, p4x, q1c;
  logic [63:0] s7_q2, s7_d0;
  logic [19:0] s7_rp;
  side_t       sd7;

  assign qp5x = {{22{s6_qp5[41]}}, s6_qp5};
  assign qp2x = {{22{s6_qp2[41]}}, s6_qp2};
  assign p4x  = {{48{cal.p4[15]}}, cal.p4};
  assign q1c  = {{8{s6_q1b[63]}}, s6_q1b[63:8]} + (qp2x << 12);

  always_ff @(posedge clk) begin
    s7_q2 <= s6_q2a + (qp5x << 17) + (p4x << 35);
    s7_d0 <= q1c + D_BIAS;
    s7_rp <= s6_rp;
    sd7   <= sd6;
  end

  // stage 8: divisor scale, dividend base
  logic [79:0] dm_full;
  logic [20:0] rp21;
  logic [63:0] s8_dm, s8_pn;
  side_t       sd8;

  assign dm_full = s7_d0 * cal.p1;
  assign rp21    = PRESS_FULL - {1'b0, s7_rp};

  always_ff @(posedge clk) begin
    s8_dm <= dm_full[63:0];
    s8_pn <= {12'b0, rp21, 31'b0} - s7_q2;
    sd8   <= sd7;
  end

  // stage 9: final dividend and divisor
  logic [75:0]      num_full;
  logic [63:0]      s9_num;
  logic [DEN_W-1:0] s9_den;
  side_t            sd9_now, sd9;

  assign num_full = s8_pn * P_SCALE;

  always_comb begin
    sd9_now          = sd8;
    sd9_now.div_zero = (s8_dm[63:33] == '0);
  end

  always_ff @(posedge clk) begin
    s9_num <= num_full[63:0];
    s9_den <= s8_dm[63:33];
    sd9    <= sd9_now;
  end

  // stage 10: magnitudes and quotient sign
  side_t sd10_now;

  always_comb begin
    sd10_now     = sd9;
    sd10_now.neg = s9_num[63] ^ s9_den[DEN_W-1];
  end

  always_ff @(posedge clk) begin
    num_mag <= s9_num[63] ? (64'd0 - s9_num) : s9_num;
    den_mag <= s9_den[DEN_W-1] ? (DEN_W'(0) - s9_den) : s9_den;
    side    <= sd10_now;
  end

endmodule

`default_nettype wire

@@ hdl/bpc_div.sv @@
// ----------------------------------------------------------------------------
// bpc_div - pipelined restoring divider
// Unsigned 64-bit by 31-bit division, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div import bpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [63:0]        num_mag,
  input  logic [DEN_W-1:0]   den_mag,
  input  side_t              side_in,
  output logic               out_valid,
  output logic [63:0]        quot,
  output side_t              side_out
);

  // stage k holds the partial remainder and the dividend/quotient shift word
  logic                vld_q  [0:DIV_BITS];
  logic [DEN_W-1:0]    rem_q  [0:DIV_BITS];
  logic [63:0]         word_q [0:DIV_BITS];
  logic [DEN_W-1:0]    den_q  [0:DIV_BITS];
  side_t               side_q [0:DIV_BITS];

  assign vld_q[0]  = in_valid;
  assign rem_q[0]  = '0;
  assign word_q[0] = num_mag;
  assign den_q[0]  = den_mag;
  assign side_q[0] = side_in;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    // trial subtract of the divisor
    assign trial = {rem_q[k], word_q[k][63]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign ge    = (trial >= {1'b0, den_q[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      word_q[k+1] <= {word_q[k][62:0], ge};
      den_q[k+1]  <= den_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign out_valid = vld_q[DIV_BITS];
  assign quot      = word_q[DIV_BITS];
  assign side_out  = side_q[DIV_BITS];

endmodule

`default_nettype wire

@@ hdl/bpc_back.sv @@
// ----------------------------------------------------------------------------
// bpc_back - post-division pressure correction and result formatting
// Six stages: sign, nonlinear terms, final pressure, range check, output.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_back import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] quot,
  input  side_t       side_in,
  input  cal_t        cal,
  output logic        out_valid,
  output result_t     result
);

  logic [BACK_STAGES-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[BACK_STAGES-2:0], in_valid};
    end
  end
  assign out_valid = vld[BACK_STAGES-1];

  // stage 1: signed quotient and its coarse copy
  logic [63:0] qs, b1_q, b1_ps;
  side_t       sd1;

  assign qs = side_in.neg ? (64'd0 - quot) : quot;

  always_ff @(posedge clk) begin
    b1_q  <= qs;
    b1_ps <= {{13{qs[63]}}, qs[63:13]};
    sd1   <= side_in;
  end

  // stage 2: partial products of the square, linear p8 term
  logic [63:0]        ll;
  logic [30:0]        lh;
  logic signed [79:0] r2_full;
  logic [63:0]        b2_ll, b2_r2m, b2_q;
  logic [30:0]        b2_lh;
  side_t              sd2;

  assign ll      = b1_ps[31:0] * b1_ps[31:0];
  assign lh      = 31'(b1_ps[31:0] * b1_ps[63:32]);
  assign r2_full = $signed(b1_q) * cal.p8;

  always_ff @(posedge clk) begin
    b2_ll  <= ll;
    b2_lh  <= lh;
    b2_r2m <= r2_full[63:0];
    b2_q   <= b1_q;
    sd2    <= sd1;
  end

  // stage 3: square modulo 2^64
  logic [63:0] b3_sq, b3_r2, b3_q;
  side_t       sd3;

  always_ff @(posedge clk) begin
    b3_sq <= b2_ll + {b2_lh, 33'b0};
    b3_r2 <= {{19{b2_r2m[63]}}, b2_r2m[63:19]};
    b3_q  <= b2_q;
    sd3   <= sd2;
  end

  // stage 4: p9 times square
  logic signed [79:0] r1_full;
  logic [63:0]        b4_r1m, b4_r2, b4_q;
  side_t              sd4;

  assign r1_full = $signed(b3_sq) * cal.p9;

  always_ff @(posedge clk) begin
    b4_r1m <= r1_full[63:0];
    b4_r2  <= b3_r2;
    b4_q   <= b3_q;
    sd4    <= sd3;
  end

  // stage 5: corrected sum
  logic [63:0] b5_s;
  side_t       sd5;

  always_ff @(posedge clk) begin
    b5_s <= b4_q + {{25{b4_r1m[63]}}, b4_r1m[63:25]} + b4_r2;
    sd5  <= sd4;
  end

  // stage 6: final pressure, range check, fault priority
  logic [63:0] pf;
  logic        press_ok;
  result_t     res_next;

  assign pf       = {{8{b5_s[63]}}, b5_s[63:8]} + {{44{cal.p7[15]}}, cal.p7, 4'b0};
  assign press_ok = !pf[63] && (pf != 64'd0) && (pf <= PRESS_MAX);

  always_comb begin
    res_next = '0;
    if (sd5.skip) begin
      res_next.fault_code = FAULT_SKIPPED;
    end else if (sd5.div_zero) begin
      res_next.fault_code = FAULT_DIVISOR;
    end else if (sd5.temp_bad || !press_ok) begin
      res_next.fault_code = FAULT_RANGE;
    end else begin
      res_next.temperature_centi_c = sd5.temp;
      res_next.pressure_q24_8_pa   = pf[24:0];
      res_next.result_valid        = 1'b1;
      res_next.fault_code          = FAULT_OK;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

`default_nettype wire

@@ hdl/barometric_pressure_compensation_core.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core - barometer factory compensation
// Raw temperature/pressure pair in, compensated centi-degrees and Q24.8 Pa out.
// ----------------------------------------------------------------------------
// Usage:
//   Calibration words are written through cfg_valid/cfg_ready/cfg_index/
//   cfg_data (cfg_ready is always high); write them while no sample is in
//   flight. Index 0 t1..t3, 1 p1..p4, 2 p5..p8, 3 p9.
//   A sample transfer happens at a clock edge with start high and busy low.
//   busy stays low: a new sample pair may enter on every cycle.
//   Each sample produces exactly one result, presented for one cycle with
//   done high, after passing 10 stages of temperature and divisor
//   arithmetic, a 64-stage one-bit-per-stage divider, and 6 stages of
//   pressure correction and checking. Throughput is one item per cycle.
//   The result is not held: the receiver must take it in the done cycle.
//   Synchronous reset clears the calibration registers and all pipeline
//   valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation_core import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  sample_t     sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output result_t     result
);

  logic [47:0] cal_temp;
  logic [63:0] cal_pressure_low;
  logic [63:0] cal_pressure_high;
  logic [15:0] cal_pressure_p9;
  cal_t        cal;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // calibration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp          <= '0;
      cal_pressure_low  <= '0;
      cal_pressure_high <= '0;
      cal_pressure_p9   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAL_TEMP:  cal_temp          <= cfg_data[47:0];
        CFG_CAL_PLOW:  cal_pressure_low  <= cfg_data;
        CFG_CAL_PHIGH: cal_pressure_high <= cfg_data;
        CFG_CAL_P9:    cal_pressure_p9   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // coefficient unpacking
  always_comb begin
    cal.t1 = cal_temp[15:0];
    cal.t2 = cal_temp[31:16];
    cal.t3 = cal_temp[47:32];
    cal.p1 = cal_pressure_low[15:0];
    cal.p2 = cal_pressure_low[31:16];
    cal.p3 = cal_pressure_low[47:32];
    cal.p4 = cal_pressure_low[63:48];
    cal.p5 = cal_pressure_high[15:0];
    cal.p6 = cal_pressure_high[31:16];
    cal.p7 = cal_pressure_high[47:32];
    cal.p8 = cal_pressure_high[63:48];
    cal.p9 = cal_pressure_p9;
  end

  logic             f_valid, d_valid;
  logic [63:0]      f_num, d_quot;
  logic [DEN_W-1:0] f_den;
  side_t            f_side, d_side;

  bpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .sample    (sample),
    .cal       (cal),
    .out_valid (f_valid),
    .num_mag   (f_num),
    .den_mag   (f_den),
    .side      (f_side)
  );

  bpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .num_mag   (f_num),
    .den_mag   (f_den),
    .side_in   (f_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .side_out  (d_side)
  );

  bpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .quot      (d_quot),
    .side_in   (d_side),
    .cal       (cal),
    .out_valid (done),
    .result    (result)
  );

`ifndef NO_ASSERTIONS
  // every transfer yields a result with done high
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after sample transfer");

  // valid flag agrees with the fault code
  a_valid_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.result_valid == (result.fault_code == FAULT_OK)))
    else $error("result_valid inconsistent with fault_code");

  // faulted results carry zero values
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.fault_code != FAULT_OK) |->
      (result.temperature_centi_c == '0 && result.pressure_q24_8_pa == '0))
    else $error("faulted result has nonzero values");

  // valid results are inside the accepted window
  a_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.result_valid) |->
      ($signed(result.temperature_centi_c) >= -15'sd5000 &&
       $signed(result.temperature_centi_c) <= 15'sd10000 &&
       result.pressure_q24_8_pa != '0 &&
       result.pressure_q24_8_pa <= 25'd30720000))
    else $error("valid result out of range");
`endif

endmodule

`default_nettype wire

@@ tb/barometric_pressure_compensation_core_tb.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core_tb - compensation core testbench
// Drives raw sample pairs under several calibration sets, predicts each
// compensated result in 64-bit integer arithmetic and checks it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation_core_tb;
  import bpc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  sample_t     sample = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        done;
  result_t     result;

  barometric_pressure_compensation_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // calibration copy held by the predictor
  logic [47:0] cal_t_reg = '0;
  logic [63:0] cal_lo_reg = '0;
  logic [63:0] cal_hi_reg = '0;
  logic [15:0] cal_p9_reg = '0;

  sample_t sample_queue[$];
  result_t expected_results[$];
  int      errors = 0;
  int      results_seen = 0;
  int      fault_seen[4] = '{0, 0, 0, 0};
  logic    drv_enable = 1'b0;
  int      gap_left = 0;

  function automatic logic [63:0] sx(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // 64-bit integer compensation of one sample pair
  function automatic result_t compensate(input sample_t s);
    result_t r;
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] rt, rp, a, b, v1, v2, tf, temp, q1, q2, p, ps13, r1, r2;
    logic [63:0] an, ad, q;
    logic neg;
    r = '0;
    r.fault_code = FAULT_OK;
    if (s.raw_temp == RAW_SKIPPED || s.raw_press == RAW_SKIPPED) begin
      r.fault_code = FAULT_SKIPPED;
      return r;
    end
    rt = {44'd0, s.raw_temp};
    rp = {44'd0, s.raw_press};
    t1 = {48'd0, cal_t_reg[15:0]};
    t2 = sx(cal_t_reg[31:16]);
    t3 = sx(cal_t_reg[47:32]);
    p1 = {48'd0, cal_lo_reg[15:0]};
    p2 = sx(cal_lo_reg[31:16]);
    p3 = sx(cal_lo_reg[47:32]);
    p4 = sx(cal_lo_reg[63:48]);
    p5 = sx(cal_hi_reg[15:0]);
    p6 = sx(cal_hi_reg[31:16]);
    p7 = sx(cal_hi_reg[47:32]);
    p8 = sx(cal_hi_reg[63:48]);
    p9 = sx(cal_p9_reg);
    a = (rt >>> 3) - (t1 <<< 1);
    v1 = (a * t2) >>> 11;
    b = (rt >>> 4) - t1;
    v2 = (((b * b) >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    temp = (tf * 5 + 128) >>> 8;
    q1 = tf - 128000;
    q2 = q1 * q1 * p6;
    q2 = q2 + ((q1 * p5) <<< 17);
    q2 = q2 + (p4 <<< 35);
    q1 = ((q1 * q1 * p3) >>> 8) + ((q1 * p2) <<< 12);
    q1 = (((64'sd1 <<< 47) + q1) * p1) >>> 33;
    if (q1 == 0) begin
      r.fault_code = FAULT_DIVISOR;
      return r;
    end
    p = 1048576 - rp;
    p = ((p <<< 31) - q2) * 3125;
    // truncating divide done on magnitudes so the most negative case wraps
    neg = p[63] ^ q1[63];
    an = p[63] ? -p : p;
    ad = q1[63] ? -q1 : q1;
    q = an / ad;
    p = neg ? -q : q;
    ps13 = p >>> 13;
    r1 = (p9 * ps13 * ps13) >>> 25;
    r2 = (p8 * p) >>> 19;
    p = ((p + r1 + r2) >>> 8) + (p7 <<< 4);
    if (temp < -5000 || temp > 10000 || p <= 0 || p > 30720000) begin
      r.fault_code = FAULT_RANGE;
      return r;
    end
    r.temperature_centi_c = temp[14:0];
    r.pressure_q24_8_pa = p[24:0];
    r.result_valid = 1'b1;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // driver: one start transfer per pending sample, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // item just transferred; predict it, then maybe issue the next one
      expected_results.push_back(compensate(sample));
      gap_left = gap_len();
      if (drv_enable && sample_queue.size() > 0 && gap_left == 0) begin
        sample <= sample_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (drv_enable && sample_queue.size() > 0) begin
        sample <= sample_queue.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor: each done cycle is one result transfer
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        result_t exp_r;
        exp_r = expected_results.pop_front();
        fault_seen[exp_r.fault_code]++;
        if (result.temperature_centi_c !== exp_r.temperature_centi_c) begin
          $error("temperature_centi_c expected %0d got %0d",
                 exp_r.temperature_centi_c, result.temperature_centi_c);
          errors++;
        end
        if (result.pressure_q24_8_pa !== exp_r.pressure_q24_8_pa) begin
          $error("pressure_q24_8_pa expected %0d got %0d",
                 exp_r.pressure_q24_8_pa, result.pressure_q24_8_pa);
          errors++;
        end
        if (result.result_valid !== exp_r.result_valid) begin
          $error("result_valid expected %0b got %0b",
                 exp_r.result_valid, result.result_valid);
          errors++;
        end
        if (result.fault_code !== exp_r.fault_code) begin
          $error("fault_code expected %0d got %0d",
                 exp_r.fault_code, result.fault_code);
          errors++;
        end
      end
    end
  end

  task automatic cal_write(input logic [1:0] idx, input logic [63:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CAL_TEMP:  cal_t_reg = data[47:0];
      CFG_CAL_PLOW:  cal_lo_reg = data;
      CFG_CAL_PHIGH: cal_hi_reg = data;
      default:       cal_p9_reg = data[15:0];
    endcase
  endtask

  task automatic load_cal(input logic [47:0] ct, input logic [63:0] lo,
                          input logic [63:0] hi, input logic [15:0] p9);
    cal_write(CFG_CAL_TEMP, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | ct);
    cal_write(CFG_CAL_PLOW, lo);
    cal_write(CFG_CAL_PHIGH, hi);
    cal_write(CFG_CAL_P9, {$urandom, 16'h0, p9} & 64'hFFFF_FFFF_0000_FFFF);
  endtask

  // let everything in flight drain while the driver holds off
  task automatic drain();
    drv_enable = 1'b0;
    while (sample_queue.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic run_phase();
    drv_enable = 1'b1;
    while (sample_queue.size() > 0) @(posedge clk);
    drain();
  endtask

  // random raw value: mostly plausible, sometimes anywhere, rarely skipped
  function automatic logic [19:0] raw_pick(input logic [19:0] lo, input logic [19:0] hi);
    int k;
    k = $urandom_range(0, 29);
    if (k == 0) return RAW_SKIPPED;
    if (k < 5) return 20'($urandom_range(0, 20'hFFFFF));
    return 20'($urandom_range(lo, hi));
  endfunction

  // a typical sensor calibration, jittered
  task automatic typical_cal(input int jitter);
    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    t1 = 16'(27504 + $urandom_range(0, jitter));
    t2 = 16'(26435 - $urandom_range(0, jitter));
    t3 = 16'(-1000 + $urandom_range(0, jitter));
    p1 = 16'(36477 + $urandom_range(0, jitter));
    p2 = 16'(-10685 + $urandom_range(0, jitter));
    p3 = 16'd3024;
    p4 = 16'(2855 + $urandom_range(0, jitter));
    p5 = 16'd140;
    p6 = -16'sd7;
    p7 = 16'(15500 - $urandom_range(0, jitter));
    p8 = -16'sd14600;
    p9 = 16'd6000;
    load_cal({t3, t2, t1}, {p4, p3, p2, p1}, {p8, p7, p6, p5}, p9);
  endtask

  task automatic fill_random(input int n);
    sample_t s;
    repeat (n) begin
      s.raw_temp = raw_pick(20'd400000, 20'd640000);
      s.raw_press = raw_pick(20'd250000, 20'd450000);
      sample_queue.push_back(s);
    end
  endtask

  initial begin
    sample_t s;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset calibration, zero divisor on every sample that is not skipped
    s = '{20'd0, 20'd0};           sample_queue.push_back(s);
    s = '{20'hFFFFF, 20'hFFFFF};   sample_queue.push_back(s);
    s = '{RAW_SKIPPED, 20'd1234};  sample_queue.push_back(s);
    run_phase();

    // directed: typical calibration and field extremes
    typical_cal(0);
    s = '{20'd519888, 20'd415148}; sample_queue.push_back(s);
    s = '{20'd0, 20'd0};           sample_queue.push_back(s);
    s = '{20'hFFFFF, 20'hFFFFF};   sample_queue.push_back(s);
    s = '{20'd0, 20'hFFFFF};       sample_queue.push_back(s);
    s = '{20'hFFFFF, 20'd0};       sample_queue.push_back(s);
    s = '{RAW_SKIPPED, 20'd415148}; sample_queue.push_back(s);
    s = '{20'd519888, RAW_SKIPPED}; sample_queue.push_back(s);
    s = '{RAW_SKIPPED, RAW_SKIPPED}; sample_queue.push_back(s);
    s = '{20'h7FFFF, 20'h80001};   sample_queue.push_back(s);
    s = '{20'h80001, 20'h7FFFF};   sample_queue.push_back(s);
    s = '{20'd560000, 20'd300000}; sample_queue.push_back(s);
    s = '{20'd450000, 20'd440000}; sample_queue.push_back(s);
    run_phase();

    // extreme calibration words
    load_cal(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    fill_random(40);
    run_phase();
    load_cal(48'h8000_8000_0000, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000, 16'h8000);
    fill_random(40);
    run_phase();
    load_cal(48'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
    fill_random(40);
    run_phase();

    // fully random calibration, once
    load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
             16'($urandom));
    fill_random(30);
    run_phase();

    // bulk: plausible calibrations with random jitter
    repeat (6) begin
      typical_cal($urandom_range(0, 3000));
      fill_random(250);
      run_phase();
    end

    $display("covered %0d results: ok %0d, skipped %0d, zero divisor %0d, out of range %0d",
             results_seen, fault_seen[0], fault_seen[1], fault_seen[2], fault_seen[3]);
    $display("calibration sets included reset zeros and all-extreme words");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/bpc_pkg.sv
hdl/bpc_front.sv
hdl/bpc_div.sv
hdl/bpc_back.sv
hdl/barometric_pressure_compensation_core.sv
tb/barometric_pressure_compensation_core_tb.sv
